// ----- rtl/lfa_pkg.sv -----
// Package for the LIFO free-list allocator: widths, limits, codes and types.
// Shared by lfa_stack_ram and lifo_free_list_allocator; depends on nothing.
package lfa_pkg;

  localparam int STACK_CAP   = 1024;
  localparam int ADDR_W      = 10;
  localparam int HANDLE_W    = 10;
  localparam int DEPTH_W     = 11;
  localparam int CHUNKS_W    = 5;
  localparam int CSIZE_W     = 7;
  localparam int CHUNK_MAX   = 64;
  localparam int MAX_CHUNKS  = 16;
  localparam int COUNT_LIMIT = 31;
  localparam int CSIZE_RESET = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } fsm_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [HANDLE_W-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } ram_req_t;

  // Register value 0 behaves as 1, values above CHUNK_MAX behave as CHUNK_MAX.
  function automatic logic [CSIZE_W-1:0] eff_size(input logic [CSIZE_W-1:0] raw);
    logic [CSIZE_W-1:0] s;
    s = raw;
    if (s == '0) s = CSIZE_W'(1);
    if (s > CSIZE_W'(CHUNK_MAX)) s = CSIZE_W'(CHUNK_MAX);
    return s;
  endfunction

endpackage

// ----- rtl/lifo_free_list_allocator.sv -----
// LIFO free-list allocator: hands out slot handles from a stack held in a 1024-entry RAM.
// A result is loaded into the output register once that register is free, from the pending registers and RAM read data.
// A new item is taken only in S_IDLE, after the result of the last one has been loaded into the output register.
// Chunk growth needs no RAM writes: fresh handles are derived from a base register.
// Reset (rst_n low, synchronous) and chunk_size writes re-form the pool at once:
// no clearing pass over the RAM is needed. Depends on lfa_pkg and lfa_stack_ram.
module lifo_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: chunk_size.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] handle, [15:10] zero
  input  logic        in_tuser,   // [0] req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [11:2] slot, [22:12] free_count,
                                  // [27:23] chunks_in_use, [31:28] zero
);

  localparam int AW = lfa_pkg::ADDR_W;
  localparam int HW = lfa_pkg::HANDLE_W;
  localparam int DW = lfa_pkg::DEPTH_W;
  localparam int NW = lfa_pkg::CHUNKS_W;
  localparam int CW = lfa_pkg::CSIZE_W;

  // Architectural state. The stack contents live in the RAM, except for the
  // bottom imp_len_r entries: those still hold the handles of the last chunk
  // that was formed, imp_base_r + index, and are never stored in the RAM.
  // A push below that region shrinks it, as everything above the top is dead.
  logic [CW-1:0] csize_r;
  logic [DW-1:0] depth_r,    depth_nxt;
  logic [NW-1:0] chunks_r,   chunks_nxt;
  logic [DW-1:0] limit_r,    limit_nxt;     // chunks_r * chunk size
  logic [CW-1:0] imp_len_r,  imp_len_nxt;
  logic [HW-1:0] imp_base_r, imp_base_nxt;

  // Result in flight between acceptance and the output register.
  logic [1:0]    pend_status_r, pend_status_nxt;
  logic          pend_grant_r,  pend_grant_nxt;
  logic          pend_imp_r,    pend_imp_nxt;
  logic [HW-1:0] pend_imp_val_r, pend_imp_val_nxt;

  // Output register.
  logic          out_valid_r;
  logic [31:0]   out_data_r;

  lfa_pkg::fsm_t     state_r, state_nxt;
  lfa_pkg::ram_req_t ram_req;
  logic [HW-1:0]     ram_rdata;

  logic          in_fire;
  logic          load_out;
  logic [CW-1:0] cs;
  logic [CW-1:0] cfg_cs;
  logic [HW-1:0] in_handle;
  logic          can_grow;
  logic [DW-1:0] pop_src;
  logic [DW-1:0] pop_idx;
  logic [CW-1:0] lo_eff;
  logic [HW-1:0] base_eff;
  logic [HW-1:0] slot;

  assign cs        = lfa_pkg::eff_size(csize_r);
  assign cfg_cs    = lfa_pkg::eff_size(cfg_wdata);
  assign in_handle = in_tdata[HW-1:0];
  assign in_fire   = in_tvalid && in_tready;

  // A new chunk fits when the count limits allow it and its handles stay in range.
  assign can_grow = (chunks_r < NW'(lfa_pkg::MAX_CHUNKS)) &&
                    (chunks_r < NW'(lfa_pkg::COUNT_LIMIT)) &&
                    ((12'(limit_r) + 12'(cs)) <= 12'(lfa_pkg::STACK_CAP));

  // Request decode: all counters are settled at acceptance; only the popped
  // handle may have to come from the RAM in the next cycle.
  always_comb begin
    depth_nxt        = depth_r;
    chunks_nxt       = chunks_r;
    limit_nxt        = limit_r;
    imp_len_nxt      = imp_len_r;
    imp_base_nxt     = imp_base_r;
    pend_status_nxt  = pend_status_r;
    pend_grant_nxt   = pend_grant_r;
    pend_imp_nxt     = pend_imp_r;
    pend_imp_val_nxt = pend_imp_val_r;
    ram_req          = '0;
    pop_src          = depth_r;
    pop_idx          = depth_r - DW'(1);
    lo_eff           = imp_len_r;
    base_eff         = imp_base_r;

    if (in_fire) begin
      pend_status_nxt = lfa_pkg::ST_OK;
      pend_grant_nxt  = 1'b0;
      pend_imp_nxt    = 1'b0;
      if (in_tuser == lfa_pkg::REQ_ACQUIRE) begin
        if (depth_r == '0 && !can_grow) begin
          pend_status_nxt = lfa_pkg::ST_EXHAUSTED;
        end else begin
          if (depth_r == '0) begin
            // Empty stack: form a new chunk in place, then pop from it.
            pop_src      = DW'(cs);
            lo_eff       = cs;
            base_eff     = limit_r[HW-1:0];
            imp_len_nxt  = cs;
            imp_base_nxt = limit_r[HW-1:0];
            limit_nxt    = limit_r + DW'(cs);
            chunks_nxt   = chunks_r + NW'(1);
          end
          pop_idx          = pop_src - DW'(1);
          depth_nxt        = pop_idx;
          pend_grant_nxt   = 1'b1;
          pend_imp_nxt     = pop_idx < DW'(lo_eff);
          pend_imp_val_nxt = base_eff + pop_idx[HW-1:0];
          ram_req.re       = 1'b1;
          ram_req.raddr    = pop_idx[AW-1:0];
        end
      end else begin
        if ({1'b0, in_handle} >= limit_r) begin
          pend_status_nxt = lfa_pkg::ST_RANGE;
        end else if (depth_r >= DW'(lfa_pkg::STACK_CAP)) begin
          pend_status_nxt = lfa_pkg::ST_OVERFLOW;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = depth_r[AW-1:0];
          ram_req.wdata = in_handle;
          depth_nxt     = depth_r + DW'(1);
          if (depth_r < DW'(imp_len_r)) begin
            imp_len_nxt = depth_r[CW-1:0];
          end
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfa_pkg::S_IDLE: if (in_fire)  state_nxt = lfa_pkg::S_RESP;
      lfa_pkg::S_RESP: if (load_out) state_nxt = lfa_pkg::S_IDLE;
      default:                       state_nxt = lfa_pkg::S_IDLE;
    endcase
  end

  // State outputs. No item is taken while reset is held.
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      lfa_pkg::S_IDLE: in_tready = rst_n;
      lfa_pkg::S_RESP: load_out  = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  assign slot = !pend_grant_r ? '0 : (pend_imp_r ? pend_imp_val_r : ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      csize_r     <= CW'(lfa_pkg::CSIZE_RESET);
      depth_r     <= DW'(lfa_pkg::eff_size(CW'(lfa_pkg::CSIZE_RESET)));
      chunks_r    <= NW'(1);
      limit_r     <= DW'(lfa_pkg::eff_size(CW'(lfa_pkg::CSIZE_RESET)));
      imp_len_r   <= lfa_pkg::eff_size(CW'(lfa_pkg::CSIZE_RESET));
      imp_base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        // A chunk_size write re-forms the pool as a single fresh chunk.
        csize_r    <= cfg_wdata;
        depth_r    <= DW'(cfg_cs);
        chunks_r   <= NW'(1);
        limit_r    <= DW'(cfg_cs);
        imp_len_r  <= cfg_cs;
        imp_base_r <= '0;
      end else begin
        depth_r    <= depth_nxt;
        chunks_r   <= chunks_nxt;
        limit_r    <= limit_nxt;
        imp_len_r  <= imp_len_nxt;
        imp_base_r <= imp_base_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r  <= pend_status_nxt;
    pend_grant_r   <= pend_grant_nxt;
    pend_imp_r     <= pend_imp_nxt;
    pend_imp_val_r <= pend_imp_val_nxt;
    if (load_out) begin
      out_data_r <= {4'b0000, chunks_r, depth_r, slot, pend_status_r};
    end
  end

  lfa_stack_ram u_stack_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/lfa_stack_ram.sv -----
// Free-stack storage: one write port, one read port with registered read data.
// Depends on lfa_pkg for widths and the access request struct.
module lfa_stack_ram (
  input  logic                         clk,
  input  lfa_pkg::ram_req_t            req,
  output logic [lfa_pkg::HANDLE_W-1:0] rdata
);

  logic [lfa_pkg::HANDLE_W-1:0] mem [lfa_pkg::STACK_CAP];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
